// ===== hw/rtl/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

    localparam int MAX_PATTERN = 64;

    localparam logic [7:0] SYM_STAR = 8'd42;
    localparam logic [7:0] SYM_ANY  = 8'd63;

    typedef enum logic [1:0] {
        REQ_CLEAR   = 2'd0,
        REQ_APPEND  = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_TEXT    = 2'd3
    } req_type_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] symbol;
    } in_item_t;

    typedef struct packed {
        logic match;
        logic overflow;
    } out_item_t;

    // Broadcast commands from the control to every cell.
    typedef struct packed {
        logic clear;
        logic append;
        logic reload;
    } cell_ctrl_t;

    // Data handed from one cell to the next during a text sweep.
    typedef struct packed {
        logic tok;
        logic old_bit;
        logic new_bit;
    } link_t;

endpackage

// ===== hw/rtl/wpm_cell.sv =====
// One pattern position: stored symbol, initial and match bits, sweep stage.
module wpm_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  wpm_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]         sym_in,
    input  logic [7:0]         text_byte,
    input  wpm_pkg::link_t     link_in,
    output wpm_pkg::link_t     link_out,
    input  logic               init_prev,
    output logic               init_out,
    input  logic               filled_prev,
    output logic               filled_out,
    input  logic               filled_next,
    output logic               tail_match,
    output logic               sweep_end
);
    import wpm_pkg::*;

    logic       filled_reg, filled_next_v;
    logic [7:0] sym_reg, sym_next;
    logic       init_reg, init_next;
    logic       match_reg, match_next;
    link_t      link_reg, link_next;
    logic       write_en, hit, star, step_bit, new_init;

    always_comb begin
        write_en = ctrl.append & filled_prev & ~filled_reg;
        hit      = (sym_reg == text_byte) || (sym_reg == SYM_ANY);
        star     = (sym_reg == SYM_STAR);
        new_init = init_prev & (sym_in == SYM_STAR);

        // A star either keeps the previous match or extends the one just made.
        if (hit) begin
            step_bit = link_in.old_bit;
        end else if (star) begin
            step_bit = match_reg | link_in.new_bit;
        end else begin
            step_bit = 1'b0;
        end

        filled_next_v = filled_reg;
        sym_next      = sym_reg;
        init_next     = init_reg;
        match_next    = match_reg;

        if (ctrl.clear) begin
            filled_next_v = 1'b0;
            init_next     = 1'b0;
            match_next    = 1'b0;
        end else if (ctrl.append) begin
            if (write_en) begin
                filled_next_v = 1'b1;
                sym_next      = sym_in;
                init_next     = new_init;
                match_next    = new_init;
            end else begin
                match_next = init_reg;
            end
        end else if (ctrl.reload) begin
            match_next = init_reg;
        end else if (link_in.tok && filled_reg) begin
            match_next = step_bit;
        end

        link_next.tok     = link_in.tok & filled_reg;
        link_next.old_bit = match_reg;
        link_next.new_bit = step_bit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= 1'b0;
            init_reg   <= 1'b0;
            match_reg  <= 1'b0;
            link_reg   <= '0;
        end else begin
            filled_reg <= filled_next_v;
            init_reg   <= init_next;
            match_reg  <= match_next;
            link_reg   <= link_next;
        end
    end

    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
    end

    assign link_out   = link_reg;
    assign init_out   = init_reg;
    assign filled_out = filled_reg;
    assign tail_match = filled_reg & ~filled_next & match_reg;
    assign sweep_end  = link_in.tok & ~filled_reg;

endmodule

// ===== hw/rtl/wildcard_pattern_matcher_top.sv =====
// Top level of the wildcard pattern matcher: request control and the cell chain.
//
// The block matches a stream of text bytes against a stored wildcard pattern of up
// to MAX_PATTERN symbols, where '?' matches any one byte and '*' matches any run of
// bytes. Each pattern symbol lives in its own cell of a chain; a cell also holds the
// match bit for the pattern prefix that ends at it. Clear, append and restart
// requests act on every cell at once in the cycle the request is accepted, and
// their result is registered once the output register is free. A text byte is
// handled by a token that walks down the chain one cell per clock, each cell
// combining its neighbour's old and new match bits; it stops at the first empty
// cell or the end of the chain. One request is worked on at a time, but a finished
// result sits in an output register, so the next request is taken while the
// result still waits for the consumer. Appends beyond capacity are dropped and
// raise overflow, which forces match low until the next clear.
module wildcard_pattern_matcher_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  wpm_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output wpm_pkg::out_item_t m_payload
);
    import wpm_pkg::*;

    localparam int N = MAX_PATTERN;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t     state_reg, state_next;
    logic       row0_reg, row0_next;
    logic       overflow_reg, overflow_next;
    logic       start_reg, start_next;
    logic       old0_reg;
    logic [7:0] text_byte_reg;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_payload_reg;

    logic       accept, full, sweep_done, out_free, match_now;
    cell_ctrl_t ctrl;
    link_t      head_link;

    link_t          link_w   [N];
    logic [N-1:0]   filled_w;
    logic [N-1:0]   init_w;
    logic [N-1:0]   tail_w;
    logic [N-1:0]   end_w;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid & s_ready;
    assign full     = filled_w[N-1];
    assign out_free = ~m_valid_reg | m_ready;

    // Commands that act on all cells in the cycle a request is taken.
    always_comb begin
        ctrl.clear  = accept && (s_payload.req_type == REQ_CLEAR);
        ctrl.append = accept && (s_payload.req_type == REQ_APPEND) && !full;
        ctrl.reload = accept && (s_payload.req_type == REQ_RESTART);
    end

    // The token enters the first cell with the old prefix-zero bit as its neighbour.
    always_comb begin
        head_link.tok     = start_reg;
        head_link.old_bit = old0_reg;
        head_link.new_bit = 1'b0;
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic init_prev_w, filled_prev_w, filled_next_w;
        wpm_pkg::link_t link_in_w;

        if (i == 0) begin : g_first
            assign init_prev_w   = 1'b1;
            assign filled_prev_w = 1'b1;
            assign link_in_w     = head_link;
        end else begin : g_rest
            assign init_prev_w   = init_w[i-1];
            assign filled_prev_w = filled_w[i-1];
            assign link_in_w     = link_w[i-1];
        end

        if (i == N - 1) begin : g_last
            assign filled_next_w = 1'b0;
        end else begin : g_inner
            assign filled_next_w = filled_w[i+1];
        end

        wpm_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .sym_in      (s_payload.symbol),
            .text_byte   (text_byte_reg),
            .link_in     (link_in_w),
            .link_out    (link_w[i]),
            .init_prev   (init_prev_w),
            .init_out    (init_w[i]),
            .filled_prev (filled_prev_w),
            .filled_out  (filled_w[i]),
            .filled_next (filled_next_w),
            .tail_match  (tail_w[i]),
            .sweep_end   (end_w[i])
        );
    end

    // The walk is over once the token meets an empty cell or leaves the last one.
    assign sweep_done = (|end_w) | link_w[N-1].tok;

    // The match bit of the whole pattern is held by the last filled cell; with an
    // empty pattern it is the prefix-zero bit.
    assign match_now = ((|tail_w) | (row0_reg & ~filled_w[0])) & ~overflow_reg;

    always_comb begin
        state_next    = state_reg;
        row0_next     = row0_reg;
        overflow_next = overflow_reg;
        start_next    = 1'b0;
        m_valid_next  = m_valid_reg & ~m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_payload.req_type)
                        REQ_CLEAR: begin
                            row0_next     = 1'b1;
                            overflow_next = 1'b0;
                            state_next    = ST_RESULT;
                        end
                        REQ_APPEND: begin
                            if (full) begin
                                overflow_next = 1'b1;
                            end else begin
                                row0_next = 1'b1;
                            end
                            state_next = ST_RESULT;
                        end
                        REQ_RESTART: begin
                            row0_next  = 1'b1;
                            state_next = ST_RESULT;
                        end
                        default: begin
                            row0_next  = 1'b0;
                            start_next = 1'b1;
                            state_next = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row0_reg     <= 1'b1;
            overflow_reg <= 1'b0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row0_reg     <= row0_next;
            overflow_reg <= overflow_next;
            start_reg    <= start_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            old0_reg      <= row0_reg;
            text_byte_reg <= s_payload.symbol;
        end
        if (state_reg == ST_RESULT && out_free) begin
            m_payload_reg.match    <= match_now;
            m_payload_reg.overflow <= overflow_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule
